/* rtl/hp6t_pkg.sv */
// Shared types and constants for the half-pel six-tap horizontal filter.
package hp6t_pkg;

	localparam int PIX_W      = 8;
	localparam int REF_WORDS  = 3;
	localparam int WORD_PIX   = 4;
	localparam int NUM_LANES  = 4;
	localparam int NUM_TAPS   = 6;
	localparam int WIN_PIX    = NUM_LANES + NUM_TAPS - 1;
	localparam int REF_W      = REF_WORDS * WORD_PIX * PIX_W;
	localparam int OFS_W      = 2;
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = NUM_LANES * PIX_W;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef pixel_t [WIN_PIX-1:0] window_t;
	typedef pixel_t [NUM_TAPS-1:0] taps_t;

	typedef struct packed {
		logic [REF_W-1:0] ref_words;
		logic [OFS_W-1:0] byte_offset;
	} align_in_t;

endpackage

/* rtl/halfpel_six_tap_horizontal_filter_unit.sv */
// Top level: align stage, four filter lanes, and the packing output register.
// Each item carries three big-endian reference words and a byte offset; the block
// returns four rounded and clipped half-pel pixels packed in one word, first pixel in
// the top byte. Items pass the align, lane and output registers, and one item is
// accepted every cycle unless all stages are full and stalled; each stage holds while the
// one after it is full and stalled, so empty stages keep filling while a result waits.
module halfpel_six_tap_horizontal_filter_unit
	import hp6t_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// ref_word0 [31:0], ref_word1 [63:32], ref_word2 [95:64], byte_offset [97:96]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// filtered_pixels [31:0]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic                  valid_s1;
	logic                  valid_s2;
	logic                  valid_s3;
	logic                  rdy1;
	logic                  rdy2;
	logic                  rdy3;
	align_in_t             ain;
	window_t               win_s1;
	pixel_t [NUM_LANES-1:0] pel_s2;
	logic [OUT_DATA_W-1:0] pack_s3;

	assign rdy3 = !valid_s3 || m_tready;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign s_tready = rdy1;
	assign m_tvalid = valid_s3;
	assign m_tdata  = pack_s3;

	assign ain.ref_words   = {s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]};
	assign ain.byte_offset = s_tdata[97:96];

	hp6t_align u_align (
		.clk    (clk),
		.en     (rdy1),
		.din    (ain),
		.win_s1 (win_s1)
	);

	for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
		hp6t_lane u_lane (
			.clk    (clk),
			.en     (rdy2),
			.taps   (win_s1[k+NUM_TAPS-1:k]),
			.pel_s2 (pel_s2[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= s_tvalid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			for (int k = 0; k < NUM_LANES; k++) begin
				pack_s3[OUT_DATA_W-1-PIX_W*k -: PIX_W] <= pel_s2[k];
			end
		end
	end

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted item did not reach the align stage");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !rdy2 |=> valid_s1 && $stable(win_s1))
		else $error("stalled align stage lost its window");

	a_s2_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rdy3 |=> m_tvalid)
		else $error("lane result did not reach the output register");

endmodule

/* rtl/hp6t_align.sv */
// Window alignment stage: shift the reference words by the byte offset.
module hp6t_align
	import hp6t_pkg::*;
(
	input  logic      clk,
	input  logic      en,
	input  align_in_t din,
	output window_t   win_s1
);

	logic [REF_W-1:0] shifted;
	window_t          win_d;

	always_comb begin
		shifted = din.ref_words << {din.byte_offset, 3'b000};
		for (int j = 0; j < WIN_PIX; j++) begin
			win_d[j] = shifted[REF_W-1-PIX_W*j -: PIX_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			win_s1 <= win_d;
		end
	end

endmodule

/* rtl/hp6t_lane.sv */
// One filter lane: six-tap sum, round, and clip to one pixel.
module hp6t_lane
	import hp6t_pkg::*;
(
	input  logic   clk,
	input  logic   en,
	input  taps_t  taps,
	output pixel_t pel_s2
);

	logic signed [14:0] outer_sum;
	logic signed [14:0] inner_sum;
	logic signed [14:0] mid_sum;
	logic signed [14:0] acc;
	logic signed [14:0] rnd;
	logic signed [14:0] shr;
	pixel_t             pel_d;

	always_comb begin
		outer_sum = $signed({7'b0, taps[0]}) + $signed({7'b0, taps[5]});
		inner_sum = $signed({7'b0, taps[1]}) + $signed({7'b0, taps[4]});
		mid_sum   = $signed({7'b0, taps[2]}) + $signed({7'b0, taps[3]});
		acc       = outer_sum - ((inner_sum <<< 2) + inner_sum)
			+ ((mid_sum <<< 4) + (mid_sum <<< 2));
		rnd       = acc + 15'sd16;
		shr       = rnd >>> 5;
		if (shr[14]) begin
			pel_d = '0;
		end else if (shr[13:8] != 6'd0) begin
			pel_d = '1;
		end else begin
			pel_d = shr[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pel_s2 <= pel_d;
		end
	end

endmodule

/* verif/tb_halfpel_six_tap_horizontal_filter_unit.sv */
// Testbench for the half-pel six-tap horizontal filter: directed and random stream traffic, scoreboard check.
class halfpel_word_tracker;
	logic [31:0] expected_words[$];
	int          errors;

	function new();
		errors = 0;
	endfunction

	// six-tap 1,-5,20,20,-5,1 over the aligned window, round, floor shift, clip
	function logic [31:0] filter_row(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
		logic [1:0] ofs);
		int          px[12];
		int          s;
		int          r;
		int          b;
		logic [95:0] cat;
		logic [31:0] res;
		cat = {w0, w1, w2};
		res = '0;
		for (int i = 0; i < 12; i++)
			px[i] = int'(cat[95 - 8 * i -: 8]);
		for (int k = 0; k < 4; k++) begin
			b = int'(ofs) + k;
			s = px[b] - 5 * px[b + 1] + 20 * px[b + 2] + 20 * px[b + 3]
				- 5 * px[b + 4] + px[b + 5];
			r = (s + 16) >>> 5;
			if (r < 0)
				r = 0;
			if (r > 255)
				r = 255;
			res = {res[23:0], r[7:0]};
		end
		return res;
	endfunction

	function void note_item(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
		logic [1:0] ofs);
		expected_words.push_back(filter_row(w0, w1, w2, ofs));
	endfunction

	function void check_word(logic [31:0] got);
		logic [31:0] want;
		if (expected_words.size() == 0) begin
			$display("%0t: filtered_pixels expected none got %08h", $time, got);
			errors++;
		end else begin
			want = expected_words.pop_front();
			if (want !== got) begin
				$display("%0t: filtered_pixels expected %08h got %08h", $time, want, got);
				errors++;
			end
		end
	endfunction

	function int pending();
		return expected_words.size();
	endfunction
endclass

module tb_halfpel_six_tap_horizontal_filter_unit;
	import hp6t_pkg::*;

	localparam int RANDOM_ITEMS = 400;
	localparam int FAST_ITEMS   = 60;
	localparam int HOLD_AT      = 30;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 200000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	halfpel_word_tracker tracker;
	int                  cycles;
	bit                  send_burst;

	halfpel_six_tap_horizontal_filter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	function automatic logic [31:0] smooth_word(int base);
		logic [31:0] w;
		int          v;
		for (int i = 0; i < 4; i++) begin
			v = base + int'($urandom_range(0, 48)) - 24;
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			w[8 * i +: 8] = v[7:0];
		end
		return w;
	endfunction

	// offer one item after a gap, hold until accepted; leaves at a falling edge
	task automatic send_item(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
		logic [1:0] ofs, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, ofs, w2, w1, w0};
		do
			@(posedge clk);
		while (!s_tready);
		tracker.note_item(w0, w1, w2, ofs);
		@(negedge clk);
	endtask

	function automatic int draw_gap();
		if (($urandom_range(0, 15)) == 0)
			send_burst = ~send_burst;
		return send_burst ? 0 : int'($urandom_range(0, 14));
	endfunction

	task automatic run_directed();
		for (int o = 0; o < 4; o++) begin
			send_item(32'h0, 32'h0, 32'h0, o[1:0], draw_gap());
			send_item(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, o[1:0], draw_gap());
			send_item(32'h00FF00FF, 32'h00FF00FF, 32'h00FF00FF, o[1:0], draw_gap());
			send_item(32'h00102030, 32'h40506070, 32'h8090A0B0, o[1:0], draw_gap());
		end
		// negative sum floors and clips to zero
		send_item(32'h00FF0000, 32'hFF000000, 32'h0, 2'd0, draw_gap());
		// large positive sum clips to 255
		send_item(32'h0000FFFF, 32'h0, 32'h0, 2'd0, draw_gap());
		// bytes past the window must not matter
		send_item(32'h01020304, 32'h05060708, 32'h12FFFFFF, 2'd0, draw_gap());
		send_item(32'h01020304, 32'h05060708, 32'h12000000, 2'd0, draw_gap());
		// rounding just below the half step
		send_item(32'h00000101, 32'h0, 32'h0, 2'd0, draw_gap());
	endtask

	task automatic run_random();
		int          base;
		int          gap;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 9) < 6) begin
				base = $urandom_range(0, 255);
				w0 = smooth_word(base);
				w1 = smooth_word(base);
				w2 = smooth_word(base);
			end else begin
				w0 = $urandom;
				w1 = $urandom;
				w2 = $urandom;
			end
			gap = (n < FAST_ITEMS) ? 0 : draw_gap();
			send_item(w0, w1, w2, 2'($urandom_range(0, 3)), gap);
		end
		s_tvalid <= 1'b0;
	endtask

	// result side: random stall per item, one long hold to back up the pipe
	initial begin
		int  stall;
		int  got;
		bit  burst;
		got   = 0;
		burst = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (($urandom_range(0, 15)) == 0)
				burst = ~burst;
			stall = burst ? 0 : int'($urandom_range(0, 14));
			if (got == HOLD_AT)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			tracker.check_word(m_tdata);
			got++;
			@(negedge clk);
		end
	end

	initial begin
		tracker    = new();
		send_burst = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		run_directed();
		run_random();
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
